@@ design/bsws_pkg.sv @@
package bsws_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 16;
  localparam int WL_W     = 11;
  localparam int WAKE_W   = 32;
  localparam int CNT32_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Item kinds.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;

  // Operating modes.
  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_IDLE   = 2'd1;
  localparam logic [1:0] MODE_BURST  = 2'd2;

  // Register indexes (byte address bit 2).
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_WAKE_INTERVAL = 1'b1;

  // Register reset values.
  localparam logic [WL_W-1:0]   WL_RESET   = 11'd200;
  localparam logic [WAKE_W-1:0] WAKE_RESET = 32'd5000000;

  // Window reset values for the running extremes.
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

  // Millivolt scaling: x * 3600 / 4096, truncated toward zero.
  localparam int MV_PROD_W = 29;
  localparam int MV_SHIFT  = 12;
  localparam logic signed [MV_PROD_W-1:0] MV_SCALE    = 29'sd3600;
  localparam logic signed [MV_PROD_W-1:0] MV_ROUND_IN = 29'sd4095;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic window_full;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  // Scale a raw sample to millivolts with truncation toward zero.
  function automatic logic signed [SAMPLE_W-1:0] to_mv(input logic signed [SAMPLE_W-1:0] x);
    logic signed [MV_PROD_W-1:0] p;
    p = MV_PROD_W'(x) * MV_SCALE;
    if (p[MV_PROD_W-1]) begin
      p = p + MV_ROUND_IN;
    end
    return p[MV_SHIFT+SAMPLE_W-1:MV_SHIFT];
  endfunction

endpackage

@@ design/bsws_item_if.sv @@
interface bsws_item_if;
  import bsws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       button_changed;
  logic                       button_down;

  modport source (output valid, cmd, sample, button_changed, button_down, input ready);
  modport sink (input valid, cmd, sample, button_changed, button_down, output ready);
endinterface

@@ design/bsws_result_if.sv @@
interface bsws_result_if;
  import bsws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       from_burst;
  logic [CNT32_W-1:0]         window_number;
  logic [CNT32_W-1:0]         burst_number;
  logic signed [SAMPLE_W-1:0] average_raw;
  logic signed [SAMPLE_W-1:0] minimum_raw;
  logic signed [SAMPLE_W-1:0] maximum_raw;
  logic signed [SAMPLE_W-1:0] average_mv;
  logic signed [SAMPLE_W-1:0] minimum_mv;
  logic signed [SAMPLE_W-1:0] maximum_mv;

  modport source (output valid, from_burst, window_number, burst_number, average_raw,
                  minimum_raw, maximum_raw, average_mv, minimum_mv, maximum_mv,
                  input ready);
  modport sink (input valid, from_burst, window_number, burst_number, average_raw,
                minimum_raw, maximum_raw, average_mv, minimum_mv, maximum_mv,
                output ready);
endinterface

@@ design/bsws_div.sv @@
module bsws_div #(
  parameter int DW = 27,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          fits;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem, quo[DW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign quotient = quo;
endmodule

@@ design/bsws_ctrl.sv @@
module bsws_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  bsws_pkg::dp_status_t  sts,
  output bsws_pkg::ctrl_cmd_t   cmd
);
  import bsws_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Items are taken only between windows.
  assign item_ready    = (state == ST_IDLE);
  assign cmd.accept    = item_ready & item_valid;
  assign cmd.div_start = (state == ST_START);
  assign cmd.finish    = (state == ST_OUT) & sts.out_free;

  // Sequencing of the end-of-window divide and result load.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.window_full) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ design/bsws_dp.sv @@
module bsws_dp #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bsws_pkg::ctrl_cmd_t                   cmd,
  output bsws_pkg::dp_status_t                  sts,
  input  logic [1:0]                            item_cmd,
  input  logic signed [bsws_pkg::SAMPLE_W-1:0]  item_sample,
  input  logic                                  item_button_changed,
  input  logic                                  item_button_down,
  input  logic [bsws_pkg::WL_W-1:0]             window_length,
  input  logic [bsws_pkg::WAKE_W-1:0]           wake_interval_ticks,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_from_burst,
  output logic [bsws_pkg::CNT32_W-1:0]          out_window_number,
  output logic [bsws_pkg::CNT32_W-1:0]          out_burst_number,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_average_raw,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_minimum_raw,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_maximum_raw,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_average_mv,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_minimum_mv,
  output logic signed [bsws_pkg::SAMPLE_W-1:0]  out_maximum_mv
);
  import bsws_pkg::*;

  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_W + CNTW;
  localparam int CW   = (CNTW > WL_W) ? CNTW : WL_W;

  logic [1:0]                 mode;
  logic [WAKE_W-1:0]          wake_countdown;
  logic [CNTW-1:0]            samples_taken;
  logic signed [SAMPLE_W-1:0] running_min;
  logic signed [SAMPLE_W-1:0] running_max;
  logic signed [SUMW-1:0]     running_sum;
  logic [CNT32_W-1:0]         windows_done;
  logic [CNT32_W-1:0]         bursts_done;
  logic                       sum_neg;

  logic [CW-1:0]              wl_ext;
  logic [CW-1:0]              eff_len;
  logic [CW-1:0]              count_inc;
  logic                       sampling;
  logic                       take_sample;
  logic                       press;
  logic [SUMW-1:0]            sum_mag;
  logic [SUMW-1:0]            quotient;
  logic signed [SAMPLE_W-1:0] avg;
  logic                       burst_win;
  logic [CNT32_W-1:0]         windows_inc;
  logic [CNT32_W-1:0]         bursts_inc;

  // Window length clamped to one through MAX_WINDOW.
  assign wl_ext  = CW'(window_length);
  assign eff_len = (wl_ext == '0) ? CW'(1) :
                   (wl_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : wl_ext;

  assign sampling    = (mode == MODE_ACTIVE) || (mode == MODE_BURST);
  assign take_sample = cmd.accept && (item_cmd == CMD_SAMPLE) && sampling;
  assign press       = item_button_changed && item_button_down;
  assign count_inc   = CW'(samples_taken) + CW'(1);

  assign sts.window_full = (item_cmd == CMD_SAMPLE) && sampling && (count_inc >= eff_len);
  assign sts.out_free    = !out_valid || out_ready;

  // Magnitude division, sign restored afterwards for truncation toward zero.
  assign sum_mag = running_sum[SUMW-1] ? SUMW'(-running_sum) : SUMW'(running_sum);

  bsws_div #(
    .DW (SUMW),
    .VW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (samples_taken),
    .busy     (sts.div_busy),
    .quotient (quotient)
  );

  assign avg         = sum_neg ? -quotient[SAMPLE_W-1:0] : quotient[SAMPLE_W-1:0];
  assign burst_win   = (mode == MODE_BURST);
  assign windows_inc = windows_done + 1'b1;
  assign bursts_inc  = burst_win ? (bursts_done + 1'b1) : bursts_done;

  // Mode, countdown and running window statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_ACTIVE;
      wake_countdown <= '0;
      samples_taken  <= '0;
      running_min    <= S16_MAX;
      running_max    <= S16_MIN;
      running_sum    <= '0;
      windows_done   <= '0;
      bursts_done    <= '0;
    end else if (cmd.finish) begin
      windows_done  <= windows_inc;
      bursts_done   <= bursts_inc;
      samples_taken <= '0;
      running_min   <= S16_MAX;
      running_max   <= S16_MIN;
      running_sum   <= '0;
      if (burst_win) begin
        mode           <= MODE_IDLE;
        wake_countdown <= wake_interval_ticks;
      end
    end else if (cmd.accept) begin
      case (item_cmd)
        CMD_TICK: begin
          if (mode == MODE_IDLE) begin
            if (wake_countdown <= WAKE_W'(1)) begin
              wake_countdown <= '0;
              mode           <= MODE_BURST;
              samples_taken  <= '0;
              running_min    <= S16_MAX;
              running_max    <= S16_MIN;
              running_sum    <= '0;
            end else begin
              wake_countdown <= wake_countdown - 1'b1;
            end
          end
        end
        CMD_SAMPLE: begin
          if (take_sample) begin
            if (item_sample < running_min) begin
              running_min <= item_sample;
            end
            if (item_sample > running_max) begin
              running_max <= item_sample;
            end
            running_sum   <= running_sum + SUMW'(item_sample);
            samples_taken <= samples_taken + 1'b1;
          end
        end
        CMD_BUTTON: begin
          if (press && (mode == MODE_ACTIVE)) begin
            mode           <= MODE_IDLE;
            wake_countdown <= wake_interval_ticks;
            samples_taken  <= '0;
            running_min    <= S16_MAX;
            running_max    <= S16_MIN;
            running_sum    <= '0;
          end else if (press && (mode == MODE_IDLE)) begin
            mode          <= MODE_ACTIVE;
            samples_taken <= '0;
            running_min   <= S16_MAX;
            running_max   <= S16_MIN;
            running_sum   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sign of the sum captured with the divide.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sum_neg <= running_sum[SUMW-1];
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_from_burst    <= burst_win;
      out_window_number <= windows_inc;
      out_burst_number  <= bursts_inc;
      out_average_raw   <= avg;
      out_minimum_raw   <= running_min;
      out_maximum_raw   <= running_max;
      out_average_mv    <= to_mv(avg);
      out_minimum_mv    <= to_mv(running_min);
      out_maximum_mv    <= to_mv(running_max);
    end
  end
endmodule

@@ design/burst_sampler_window_stats.sv @@
// Channel   Dir  Payload                                         Beat when
// item      in   cmd, sample, button_changed, button_down        valid & ready
// result    out  from_burst, window/burst numbers, raw/mv stats  valid & ready
// apb       in   window_length (0x0), wake_interval_ticks (0x4)  psel & penable & pwrite
//
// A tick, a button change or a sample that does not close a window leaves item.ready high.
// A sample that closes a window holds item.ready low through the start, divide and output
// states; the divide is paced by the one-bit-per-cycle restoring divider.
// The output state waits while an earlier result is still held in the result register.
// Reset is synchronous on rst; it clears control, mode, counters and the result valid flag.
module burst_sampler_window_stats #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  bsws_item_if.sink             item,
  bsws_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [bsws_pkg::PADDR_W-1:0] paddr,
  input  logic [bsws_pkg::PDATA_W-1:0] pwdata,
  output logic [bsws_pkg::PDATA_W-1:0] prdata,
  output logic                  pready
);
  import bsws_pkg::*;

  logic [WL_W-1:0]   window_length;
  logic [WAKE_W-1:0] wake_interval_ticks;
  logic              reg_write;
  ctrl_cmd_t         cmd;
  dp_status_t        sts;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length       <= WL_RESET;
      wake_interval_ticks <= WAKE_RESET;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: window_length       <= pwdata[WL_W-1:0];
        REG_WAKE_INTERVAL: wake_interval_ticks <= pwdata[WAKE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = PDATA_W'(window_length);
      REG_WAKE_INTERVAL: prdata = PDATA_W'(wake_interval_ticks);
      default:           prdata = '0;
    endcase
  end

  bsws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bsws_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .item_cmd            (item.cmd),
    .item_sample         (item.sample),
    .item_button_changed (item.button_changed),
    .item_button_down    (item.button_down),
    .window_length       (window_length),
    .wake_interval_ticks (wake_interval_ticks),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .out_from_burst      (result.from_burst),
    .out_window_number   (result.window_number),
    .out_burst_number    (result.burst_number),
    .out_average_raw     (result.average_raw),
    .out_minimum_raw     (result.minimum_raw),
    .out_maximum_raw     (result.maximum_raw),
    .out_average_mv      (result.average_mv),
    .out_minimum_mv      (result.minimum_mv),
    .out_maximum_mv      (result.maximum_mv)
  );
endmodule

@@ design/bsws_checker.sv @@
module bsws_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] window_number
);

  // A held result stays offered.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // A held result keeps its window number.
  a_number_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(window_number))
    else $error("window number changed while stalled");

  // A new result is only loaded while items are being refused.
  a_load_blocks_items: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result loaded while items were being taken");

  // No result is produced in the cycle right after an item beat.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared one cycle after an item");

  // Reset clears the result valid flag, so nothing is offered right after it.
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
endmodule

bind burst_sampler_window_stats bsws_checker u_bsws_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .window_number (result.window_number)
);

@@ tb/sv/tb_burst_sampler_window_stats.sv @@
module tb_burst_sampler_window_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import bsws_pkg::*;

  localparam int MAX_WINDOW = 1024;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  sample;
    logic                button_changed;
    logic                button_down;
  } beat_t;

  typedef struct packed {
    logic                from_burst;
    logic [31:0]         window_number;
    logic [31:0]         burst_number;
    logic signed [15:0]  average_raw;
    logic signed [15:0]  minimum_raw;
    logic signed [15:0]  maximum_raw;
    logic signed [15:0]  average_mv;
    logic signed [15:0]  minimum_mv;
    logic signed [15:0]  maximum_mv;
  } window_stats_t;

  // One row of the directed sequence: either a register write or an item beat.
  typedef struct {
    bit            is_write;
    logic          reg_sel;
    logic [31:0]   value;
    beat_t         beat;
    bit            typed;
    window_stats_t want;
  } plan_row_t;

  typedef struct {
    logic [31:0] window_len;
    logic [31:0] wake;
    int          beats;
    bit          idles;
    bit          buttons;
    bit          holdoff;
    bit          pause;
  } phase_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  bsws_item_if   item_bus();
  bsws_result_if result_bus();

  burst_sampler_window_stats #(.MAX_WINDOW(MAX_WINDOW)) u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Front-end state as the block should hold it, plus its register copies.
  logic [10:0] window_len_reg = WL_RESET;
  logic [31:0] wake_interval_reg = WAKE_RESET;
  logic [1:0]  fe_mode = MODE_ACTIVE;
  logic [31:0] wake_left = '0;
  int          taken = 0;
  int          run_min = 32767;
  int          run_max = -32768;
  longint      run_sum = 0;
  logic [31:0] windows_done = '0;
  logic [31:0] bursts_done = '0;

  window_stats_t pending_windows[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit beat_idles = 1'b1;
  bit result_idles = 1'b1;
  bit holdoff_req = 1'b0;

  function automatic void clear_window();
    taken = 0;
    run_min = 32767;
    run_max = -32768;
    run_sum = 0;
  endfunction

  function automatic void enter_idle();
    fe_mode = MODE_IDLE;
    wake_left = wake_interval_reg;
    clear_window();
  endfunction

  function automatic int scale_mv(input int x);
    return (x * 3600) / 4096;
  endfunction

  // Applies one accepted beat; returns 1 when it closes a window.
  function automatic bit advance_front_end(input beat_t b, output window_stats_t res);
    int     s;
    int     len;
    int     avg;
    res = '0;
    case (b.cmd)
      CMD_TICK: begin
        if (fe_mode == MODE_IDLE) begin
          if (wake_left <= 32'd1) begin
            wake_left = '0;
            fe_mode = MODE_BURST;
            clear_window();
          end else begin
            wake_left = wake_left - 32'd1;
          end
        end
      end
      CMD_BUTTON: begin
        // Only a press counts, and a burst ignores it.
        if (b.button_changed && b.button_down) begin
          if (fe_mode == MODE_ACTIVE) begin
            enter_idle();
          end else if (fe_mode == MODE_IDLE) begin
            fe_mode = MODE_ACTIVE;
            clear_window();
          end
        end
      end
      CMD_SAMPLE: begin
        if (fe_mode != MODE_IDLE) begin
          s = b.sample;
          if (s < run_min) run_min = s;
          if (s > run_max) run_max = s;
          run_sum += s;
          taken++;
          len = window_len_reg;
          if (len == 0) len = 1;
          if (len > MAX_WINDOW) len = MAX_WINDOW;
          if (taken < len) return 1'b0;
          avg = int'(run_sum / longint'(taken));
          windows_done = windows_done + 32'd1;
          if (fe_mode == MODE_BURST) bursts_done = bursts_done + 32'd1;
          res.from_burst    = (fe_mode == MODE_BURST);
          res.window_number = windows_done;
          res.burst_number  = bursts_done;
          res.average_raw   = 16'(avg);
          res.minimum_raw   = 16'(run_min);
          res.maximum_raw   = 16'(run_max);
          res.average_mv    = 16'(scale_mv(avg));
          res.minimum_mv    = 16'(scale_mv(run_min));
          res.maximum_mv    = 16'(scale_mv(run_max));
          if (fe_mode == MODE_BURST) enter_idle();
          else clear_window();
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return S16_MAX;
      1: return S16_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic for the current mode: ticks while idle,
  // samples while active or in a burst, with presses and noise mixed in.
  function automatic beat_t random_beat(input bit buttons);
    beat_t b;
    int    roll;
    roll = $urandom_range(99);
    b.sample = rand_sample();
    b.button_changed = 1'($urandom_range(1));
    b.button_down = 1'($urandom_range(1));
    if (fe_mode == MODE_IDLE) begin
      b.cmd = roll < 78 ? CMD_TICK : roll < 90 ? CMD_BUTTON : roll < 95 ? CMD_UNUSED
            : CMD_SAMPLE;
    end else begin
      b.cmd = roll < 80 ? CMD_SAMPLE : roll < 88 ? CMD_TICK : roll < 95 ? CMD_BUTTON
            : CMD_UNUSED;
    end
    if (b.cmd == CMD_BUTTON) begin
      if (!buttons) begin
        b.cmd = CMD_SAMPLE;
      end else if ($urandom_range(3) != 0) begin
        b.button_changed = 1'b1;
        b.button_down = 1'b1;
      end
    end
    return b;
  endfunction

  function automatic plan_row_t row_beat(input logic [1:0] cmd, input int sample,
                                         input bit changed, input bit down);
    plan_row_t r;
    r = '{default: '0};
    r.beat = '{cmd: cmd, sample: 16'(sample), button_changed: changed, button_down: down};
    return r;
  endfunction

  function automatic plan_row_t row_write(input logic sel, input logic [31:0] value);
    plan_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  // A one-sample window: average, minimum and maximum all equal the sample.
  function automatic plan_row_t row_single(input int sample, input bit burst,
                                           input int wn, input int bn, input int mv);
    plan_row_t r;
    r = row_beat(CMD_SAMPLE, sample, 1'b0, 1'b0);
    r.typed = 1'b1;
    r.want = '{from_burst: burst, window_number: 32'(wn), burst_number: 32'(bn),
               average_raw: 16'(sample), minimum_raw: 16'(sample), maximum_raw: 16'(sample),
               average_mv: 16'(mv), minimum_mv: 16'(mv), maximum_mv: 16'(mv)};
    return r;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one beat, with random idle cycles first, and records what it should cause.
  task automatic push_beat(input beat_t b, input bit typed, input window_stats_t want);
    window_stats_t res;
    while (beat_idles && $urandom_range(99) < 31) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.cmd            <= b.cmd;
    item_bus.sample         <= b.sample;
    item_bus.button_changed <= b.button_changed;
    item_bus.button_down    <= b.button_down;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if (advance_front_end(b, res)) pending_windows.push_back(typed ? want : res);
  endtask

  // Stops offering beats until every window is out and the block has gone quiet.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_WINDOW_LENGTH) window_len_reg = value[10:0];
    else wake_interval_reg = value;
  endtask

  // Result side: checks each beat against the oldest pending window and
  // throttles ready, including one long hold-off on request.
  initial begin : result_sink
    int            stall;
    window_stats_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_bus.valid && result_bus.ready) begin
          if (pending_windows.size() == 0) begin
            $display("%0t: result beat with no window pending, expected none, got window %0d",
                     $time, result_bus.window_number);
            mismatches++;
          end else begin
            want = pending_windows.pop_front();
            compare_field("from_burst", want.from_burst, result_bus.from_burst);
            compare_field("window_number", want.window_number, result_bus.window_number);
            compare_field("burst_number", want.burst_number, result_bus.burst_number);
            compare_field("average_raw", want.average_raw, result_bus.average_raw);
            compare_field("minimum_raw", want.minimum_raw, result_bus.minimum_raw);
            compare_field("maximum_raw", want.maximum_raw, result_bus.maximum_raw);
            compare_field("average_mv", want.average_mv, result_bus.average_mv);
            compare_field("minimum_mv", want.minimum_mv, result_bus.minimum_mv);
            compare_field("maximum_mv", want.maximum_mv, result_bus.maximum_mv);
          end
        end
        if (holdoff_req) begin
          stall = HOLDOFF_CYCLES;
          holdoff_req = 1'b0;
        end
        if (stall > 0) begin
          stall--;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= !(result_idles && $urandom_range(99) < 31);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("[burst_sampler_window_stats] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t     directed_plan[$];
    phase_t        phases[6];
    window_stats_t none;
    beat_t         press;
    none = '0;
    press = '{cmd: CMD_BUTTON, sample: '0, button_changed: 1'b1, button_down: 1'b1};
    phases = '{
      '{32'd1,    32'd1,         120,  1'b1, 1'b1, 1'b1, 1'b0},
      '{32'd4,    32'd3,         180,  1'b1, 1'b1, 1'b0, 1'b0},
      '{32'd7,    32'd0,         150,  1'b0, 1'b1, 1'b0, 1'b0},
      '{32'd2047, 32'd2,         400,  1'b0, 1'b0, 1'b0, 1'b0},
      '{32'd5,    32'hFFFF_FFFF, 80,   1'b1, 1'b1, 1'b0, 1'b0},
      '{32'd3,    32'd5,         180,  1'b1, 1'b1, 1'b0, 1'b1}
    };

    item_bus.valid          <= 1'b0;
    item_bus.cmd            <= CMD_TICK;
    item_bus.sample         <= '0;
    item_bus.button_changed <= 1'b0;
    item_bus.button_down    <= 1'b0;
    result_bus.ready        <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: ignored beats, length changes, the extremes, and a
    // short tour through idle and burst.
    directed_plan.push_back(row_beat(CMD_TICK, 0, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_UNUSED, 32767, 1'b1, 1'b1));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 1000, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b0));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b0, 1'b1));
    // Upper data bits fall outside the 11-bit length field.
    directed_plan.push_back(row_write(REG_WINDOW_LENGTH, 32'hFFFF_F801));
    directed_plan.push_back(row_beat(CMD_SAMPLE, -3000, 1'b0, 1'b0));
    directed_plan.push_back(row_single(32767, 1'b0, 2, 0, 28799));
    directed_plan.push_back(row_single(-32768, 1'b0, 3, 0, -28800));
    directed_plan.push_back(row_single(-1, 1'b0, 4, 0, 0));
    directed_plan.push_back(row_write(REG_WINDOW_LENGTH, 32'd0));
    directed_plan.push_back(row_single(4096, 1'b0, 5, 0, 3600));
    directed_plan.push_back(row_write(REG_WAKE_INTERVAL, 32'd0));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 5, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_TICK, 0, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));
    directed_plan.push_back(row_single(-4096, 1'b1, 6, 1, -3600));
    directed_plan.push_back(row_beat(CMD_TICK, 0, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 1234, 1'b0, 1'b0));
    directed_plan.push_back(row_write(REG_WAKE_INTERVAL, 32'd2));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));
    directed_plan.push_back(row_beat(CMD_TICK, 0, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_TICK, 0, 1'b0, 1'b0));
    directed_plan.push_back(row_write(REG_WINDOW_LENGTH, 32'd3));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 10, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_SAMPLE, -20, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 31, 1'b0, 1'b0));
    // Re-enter active, then leave it with a partial window so it is thrown away.
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));
    directed_plan.push_back(row_beat(CMD_SAMPLE, 7, 1'b0, 1'b0));
    directed_plan.push_back(row_beat(CMD_BUTTON, 0, 1'b1, 1'b1));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        drain_results();
        apb_write(directed_plan[i].reg_sel, directed_plan[i].value);
      end else begin
        push_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases, each under its own register setting.
    foreach (phases[p]) begin
      drain_results();
      apb_write(REG_WINDOW_LENGTH, phases[p].window_len);
      apb_write(REG_WAKE_INTERVAL, phases[p].wake);
      beat_idles = phases[p].idles;
      result_idles = phases[p].idles;
      if (phases[p].holdoff) holdoff_req = 1'b1;
      // Without presses the long window needs the block out of idle first.
      if (!phases[p].buttons && fe_mode == MODE_IDLE) push_beat(press, 1'b0, none);
      for (int n = 0; n < phases[p].beats; n++) begin
        if (phases[p].pause && n == phases[p].beats / 2) drain_results();
        push_beat(random_beat(phases[p].buttons), 1'b0, none);
      end
    end

    beat_idles = 1'b1;
    result_idles = 1'b1;
    drain_results();
    if (mismatches == 0) begin
      $display("[burst_sampler_window_stats] OK");
    end else begin
      $display("[burst_sampler_window_stats] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bsws_pkg.sv
design/bsws_item_if.sv
design/bsws_result_if.sv
design/bsws_div.sv
design/bsws_ctrl.sv
design/bsws_dp.sv
design/burst_sampler_window_stats.sv
design/bsws_checker.sv
tb/sv/tb_burst_sampler_window_stats.sv
